/* rtl/bpq_pkg.sv */
// Shared constants, codes and controller/datapath interface types for the priority queue.
package bpq_pkg;

   localparam int DEPTH   = 16;
   localparam int IDX_W   = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int ELEM_W  = 32;
   localparam int PRIO_W  = 16;
   localparam int ENTRY_W = ELEM_W + PRIO_W;

   typedef enum logic [1:0] {
      CMD_ENQUEUE = 2'd0,
      CMD_DEQUEUE = 2'd1,
      CMD_PEEK    = 2'd2,
      CMD_UNUSED  = 2'd3
   } command_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SCAN,
      ST_SHIFT,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic capture;
      logic scan_start;
      logic scan_step;
      logic shift_start;
      logic shift_step;
      logic commit;
   } dp_cmd_type;

   typedef struct packed {
      command_type command;
      logic        count_zero;
      logic        walk_done;
      logic        rsp_free;
   } dp_status_type;

endpackage

/* rtl/bpq_ctrl.sv */
// Sequencing state machine: decode, priority scan, gap close and response.
module bpq_ctrl
   import bpq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if ((status.command inside {CMD_DEQUEUE, CMD_PEEK}) && !status.count_zero) begin
               state_in = ST_SCAN;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_SCAN: begin
            if (status.walk_done) begin
               state_in = (status.command == CMD_DEQUEUE) ? ST_SHIFT : ST_RESP;
            end
         end
         ST_SHIFT: begin
            if (status.walk_done) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (status.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall       = (state_ff != ST_IDLE);
      cmd             = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.capture = req_valid;
         end
         ST_DECODE: begin
            cmd.scan_start = 1'b1;
         end
         ST_SCAN: begin
            cmd.scan_step   = 1'b1;
            cmd.shift_start = status.walk_done && (status.command == CMD_DEQUEUE);
         end
         ST_SHIFT: begin
            cmd.shift_step = 1'b1;
         end
         ST_RESP: begin
            cmd.commit = status.rsp_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

/* rtl/bpq_datapath.sv */
// Entry store, scan and shift address logic, count, capacity and response registers.
module bpq_datapath
   import bpq_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic [1:0]               req_command,
   input  logic signed [ELEM_W-1:0] req_element,
   input  logic [PRIO_W-1:0]        req_priority_req,
   input  logic                     csr_write_enable,
   input  logic [CNT_W-1:0]         csr_write_data,
   input  logic                     rsp_stall,
   input  dp_cmd_type               cmd,
   output dp_status_type            status,
   output logic                     rsp_valid,
   output logic signed [ELEM_W-1:0] rsp_out_element,
   output logic [PRIO_W-1:0]        rsp_out_priority,
   output logic                     rsp_found,
   output logic                     rsp_accepted,
   output logic [CNT_W-1:0]         rsp_entry_count,
   output logic                     rsp_is_empty_flag
);

   logic [ENTRY_W-1:0] mem [DEPTH];

   logic [CNT_W-1:0]         capacity_ff, capacity_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   command_type              command_ff, command_in;
   logic signed [ELEM_W-1:0] element_ff, element_in;
   logic [PRIO_W-1:0]        priority_ff, priority_in;
   logic [CNT_W-1:0]         idx_ff, idx_in;
   logic                     pend_ff, pend_in;
   logic [IDX_W-1:0]         rd_idx_ff, rd_idx_in;
   logic [ENTRY_W-1:0]       rd_data_ff;
   logic                     first_ff, first_in;
   logic [IDX_W-1:0]         best_idx_ff, best_idx_in;
   logic signed [ELEM_W-1:0] best_elem_ff, best_elem_in;
   logic [PRIO_W-1:0]        best_prio_ff, best_prio_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [ELEM_W-1:0] rsp_elem_ff, rsp_elem_in;
   logic [PRIO_W-1:0]        rsp_prio_ff, rsp_prio_in;
   logic                     rsp_found_ff, rsp_found_in;
   logic                     rsp_acc_ff, rsp_acc_in;
   logic [CNT_W-1:0]         rsp_count_ff, rsp_count_in;

   logic                     issue;
   logic                     wr_en;
   logic [IDX_W-1:0]         wr_addr;
   logic [ENTRY_W-1:0]       wr_data;
   logic [CNT_W-1:0]         eff_cap;
   logic                     room;
   logic                     found;
   logic                     is_deq;
   logic                     is_enq;
   logic signed [ELEM_W-1:0] rd_elem;
   logic [PRIO_W-1:0]        rd_prio;

   assign rd_elem = rd_data_ff[ENTRY_W-1:PRIO_W];
   assign rd_prio = rd_data_ff[PRIO_W-1:0];
   assign is_deq  = (command_ff == CMD_DEQUEUE);
   assign is_enq  = (command_ff == CMD_ENQUEUE);
   assign found   = (is_deq || (command_ff == CMD_PEEK)) && (count_ff != '0);
   assign issue   = (cmd.scan_step || cmd.shift_step) && (idx_ff < count_ff);

   always_comb begin
      if (capacity_ff == '0) begin
         eff_cap = CNT_W'(1);
      end else if (capacity_ff > CNT_W'(DEPTH)) begin
         eff_cap = CNT_W'(DEPTH);
      end else begin
         eff_cap = capacity_ff;
      end
   end

   assign room = (count_ff < eff_cap);

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = rd_idx_ff - IDX_W'(1);
      wr_data = rd_data_ff;
      if (cmd.shift_step && pend_ff) begin
         wr_en = 1'b1;
      end else if (cmd.commit && is_enq && room) begin
         wr_en   = 1'b1;
         wr_addr = count_ff[IDX_W-1:0];
         wr_data = {element_ff, priority_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[idx_ff[IDX_W-1:0]];
   end

   always_comb begin
      capacity_in = csr_write_enable ? csr_write_data : capacity_ff;
      command_in  = cmd.capture ? command_type'(req_command) : command_ff;
      element_in  = cmd.capture ? req_element : element_ff;
      priority_in = cmd.capture ? req_priority_req : priority_ff;

      idx_in = idx_ff;
      if (cmd.scan_start) begin
         idx_in = '0;
      end else if (cmd.shift_start) begin
         idx_in = CNT_W'(best_idx_ff) + CNT_W'(1);
      end else if (issue) begin
         idx_in = idx_ff + CNT_W'(1);
      end
      pend_in   = issue;
      rd_idx_in = issue ? idx_ff[IDX_W-1:0] : rd_idx_ff;

      first_in     = first_ff;
      best_idx_in  = best_idx_ff;
      best_elem_in = best_elem_ff;
      best_prio_in = best_prio_ff;
      if (cmd.scan_start) begin
         first_in = 1'b1;
      end else if (cmd.scan_step && pend_ff) begin
         first_in = 1'b0;
         if (first_ff || (rd_prio > best_prio_ff)) begin
            best_idx_in  = rd_idx_ff;
            best_elem_in = rd_elem;
            best_prio_in = rd_prio;
         end
      end

      count_in = count_ff;
      if (cmd.commit) begin
         if (is_enq && room) begin
            count_in = count_ff + CNT_W'(1);
         end else if (is_deq && found) begin
            count_in = count_ff - CNT_W'(1);
         end
      end

      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      rsp_elem_in  = rsp_elem_ff;
      rsp_prio_in  = rsp_prio_ff;
      rsp_found_in = rsp_found_ff;
      rsp_acc_in   = rsp_acc_ff;
      rsp_count_in = rsp_count_ff;
      if (cmd.commit) begin
         rsp_elem_in  = found ? best_elem_ff : '0;
         rsp_prio_in  = found ? best_prio_ff : '0;
         rsp_found_in = found;
         rsp_acc_in   = is_enq && room;
         rsp_count_in = count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= CNT_W'(DEPTH);
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         capacity_ff  <= capacity_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      command_ff   <= command_in;
      element_ff   <= element_in;
      priority_ff  <= priority_in;
      idx_ff       <= idx_in;
      rd_idx_ff    <= rd_idx_in;
      first_ff     <= first_in;
      best_idx_ff  <= best_idx_in;
      best_elem_ff <= best_elem_in;
      best_prio_ff <= best_prio_in;
      rsp_elem_ff  <= rsp_elem_in;
      rsp_prio_ff  <= rsp_prio_in;
      rsp_found_ff <= rsp_found_in;
      rsp_acc_ff   <= rsp_acc_in;
      rsp_count_ff <= rsp_count_in;
   end

   always_comb begin
      status.command    = command_ff;
      status.count_zero = (count_ff == '0);
      status.walk_done  = (idx_ff >= count_ff) && !pend_ff;
      status.rsp_free   = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_element   = rsp_elem_ff;
   assign rsp_out_priority  = rsp_prio_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_accepted      = rsp_acc_ff;
   assign rsp_entry_count   = rsp_count_ff;
   assign rsp_is_empty_flag = (rsp_count_ff == '0);

endmodule

/* rtl/bounded_priority_queue.sv */
// Top level of the bounded priority queue: controller plus datapath.
// Holds up to 16 entries in arrival order in a single-port-write register-read
// entry store. One request at a time: enqueue, an unused command, or a peek or
// dequeue on an empty queue goes straight from decode to the response; peek
// first runs a scan that reads one entry per cycle to find the oldest entry of
// highest priority; dequeue runs the same scan and then closes the gap by moving
// each entry after the selected one down by one place. The result sits in an
// output register, so a new request is taken once the previous one has reached
// it, even while it is stalled. Capacity writes are registered, take effect in
// the next cycle and are intended while the block is idle.
module bounded_priority_queue
   import bpq_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [1:0]               req_command,
   input  logic signed [ELEM_W-1:0] req_element,
   input  logic [PRIO_W-1:0]        req_priority_req,
   input  logic                     csr_write_enable,
   input  logic [CNT_W-1:0]         csr_write_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [ELEM_W-1:0] rsp_out_element,
   output logic [PRIO_W-1:0]        rsp_out_priority,
   output logic                     rsp_found,
   output logic                     rsp_accepted,
   output logic [CNT_W-1:0]         rsp_entry_count,
   output logic                     rsp_is_empty_flag
);

   dp_cmd_type    cmd;
   dp_status_type status;

   bpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   bpq_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_command       (req_command),
      .req_element       (req_element),
      .req_priority_req  (req_priority_req),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .rsp_stall         (rsp_stall),
      .cmd               (cmd),
      .status            (status),
      .rsp_valid         (rsp_valid),
      .rsp_out_element   (rsp_out_element),
      .rsp_out_priority  (rsp_out_priority),
      .rsp_found         (rsp_found),
      .rsp_accepted      (rsp_accepted),
      .rsp_entry_count   (rsp_entry_count),
      .rsp_is_empty_flag (rsp_is_empty_flag)
   );

endmodule

/* test/bpq_checker.sv */
// Response checker for the bounded priority queue: tracks queue contents and checks every result.
`timescale 1ns / 100ps

module bpq_checker
   import bpq_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  logic [1:0]               req_command,
   input  logic signed [ELEM_W-1:0] req_element,
   input  logic [PRIO_W-1:0]        req_priority_req,
   input  logic                     csr_write_enable,
   input  logic [CNT_W-1:0]         csr_write_data,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  logic signed [ELEM_W-1:0] rsp_out_element,
   input  logic [PRIO_W-1:0]        rsp_out_priority,
   input  logic                     rsp_found,
   input  logic                     rsp_accepted,
   input  logic [CNT_W-1:0]         rsp_entry_count,
   input  logic                     rsp_is_empty_flag,
   output int                       fail_count,
   output int                       pending_count
);

   typedef struct {
      logic signed [ELEM_W-1:0] elem;
      logic [PRIO_W-1:0]        prio;
      logic                     found;
      logic                     accepted;
      logic [CNT_W-1:0]         count;
      logic                     empty;
   } queue_response_type;

   logic signed [ELEM_W-1:0] held_elem [DEPTH];
   logic [PRIO_W-1:0]        held_prio [DEPTH];
   int                       held_count;
   logic [CNT_W-1:0]         capacity_reg;
   queue_response_type       expected_responses [$];

   function automatic queue_response_type predict_response(input command_type cmd,
                                                          input logic signed [ELEM_W-1:0] elem,
                                                          input logic [PRIO_W-1:0] prio);
      queue_response_type r;
      int limit;
      int sel;
      r = '{elem: '0, prio: '0, found: 1'b0, accepted: 1'b0, count: '0, empty: 1'b0};
      limit = capacity_reg;
      if (limit < 1) limit = 1;
      if (limit > DEPTH) limit = DEPTH;
      case (cmd)
         CMD_ENQUEUE: begin
            if (held_count < limit) begin
               held_elem[held_count] = elem;
               held_prio[held_count] = prio;
               held_count++;
               r.accepted = 1'b1;
            end
         end
         CMD_DEQUEUE, CMD_PEEK: begin
            if (held_count > 0) begin
               // oldest entry wins ties: only a strictly higher priority moves the pick
               sel = 0;
               for (int i = 1; i < held_count; i++)
                  if (held_prio[i] > held_prio[sel]) sel = i;
               r.elem  = held_elem[sel];
               r.prio  = held_prio[sel];
               r.found = 1'b1;
               if (cmd == CMD_DEQUEUE) begin
                  for (int i = sel; i + 1 < held_count; i++) begin
                     held_elem[i] = held_elem[i + 1];
                     held_prio[i] = held_prio[i + 1];
                  end
                  held_count--;
               end
            end
         end
         default: ;
      endcase
      r.count = held_count[CNT_W-1:0];
      r.empty = (held_count == 0);
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (fail_count < 40)
         $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      queue_response_type want;
      if (reset) begin
         held_count   = 0;
         capacity_reg = 5'd16;
         expected_responses.delete();
      end else begin
         if (csr_write_enable)
            capacity_reg = csr_write_data;
         if (req_valid && !req_stall)
            expected_responses.push_back(predict_response(command_type'(req_command),
                                                          req_element, req_priority_req));
         if (rsp_valid && !rsp_stall) begin
            if (expected_responses.size() == 0) begin
               report_mismatch("response with no request pending", rsp_entry_count, 0);
            end else begin
               want = expected_responses.pop_front();
               if (rsp_out_element !== want.elem)
                  report_mismatch("out_element", rsp_out_element, want.elem);
               if (rsp_out_priority !== want.prio)
                  report_mismatch("out_priority", rsp_out_priority, want.prio);
               if (rsp_found !== want.found)
                  report_mismatch("found", rsp_found, want.found);
               if (rsp_accepted !== want.accepted)
                  report_mismatch("accepted", rsp_accepted, want.accepted);
               if (rsp_entry_count !== want.count)
                  report_mismatch("entry_count", rsp_entry_count, want.count);
               if (rsp_is_empty_flag !== want.empty)
                  report_mismatch("is_empty_flag", rsp_is_empty_flag, want.empty);
            end
         end
      end
      pending_count = expected_responses.size();
   end

endmodule

/* test/tb_bounded_priority_queue.sv */
// Testbench top for the bounded priority queue: clock, reset, request traffic and verdict.
`timescale 1ns / 100ps

module tb_bounded_priority_queue;
   import bpq_pkg::*;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [1:0]               req_command = CMD_ENQUEUE;
   logic signed [ELEM_W-1:0] req_element = '0;
   logic [PRIO_W-1:0]        req_priority_req = '0;
   logic                     csr_write_enable = 1'b0;
   logic [CNT_W-1:0]         csr_write_data = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic signed [ELEM_W-1:0] rsp_out_element;
   logic [PRIO_W-1:0]        rsp_out_priority;
   logic                     rsp_found;
   logic                     rsp_accepted;
   logic [CNT_W-1:0]         rsp_entry_count;
   logic                     rsp_is_empty_flag;

   int fail_count;
   int pending_count;
   int send_idle_pct = 13;
   int rsp_stall_pct = 48;

   always #1 clock = ~clock;

   bounded_priority_queue DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_element       (req_element),
      .req_priority_req  (req_priority_req),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_element   (rsp_out_element),
      .rsp_out_priority  (rsp_out_priority),
      .rsp_found         (rsp_found),
      .rsp_accepted      (rsp_accepted),
      .rsp_entry_count   (rsp_entry_count),
      .rsp_is_empty_flag (rsp_is_empty_flag)
   );

   bpq_checker response_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_element       (req_element),
      .req_priority_req  (req_priority_req),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_element   (rsp_out_element),
      .rsp_out_priority  (rsp_out_priority),
      .rsp_found         (rsp_found),
      .rsp_accepted      (rsp_accepted),
      .rsp_entry_count   (rsp_entry_count),
      .rsp_is_empty_flag (rsp_is_empty_flag),
      .fail_count        (fail_count),
      .pending_count     (pending_count)
   );

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_request(input command_type cmd, input logic signed [ELEM_W-1:0] elem,
                               input logic [PRIO_W-1:0] prio);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_command      <= cmd;
      req_element      <= elem;
      req_priority_req <= prio;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
   endtask

   task automatic write_capacity(input logic [CNT_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      command_type cmd;
      int          enq_pct;
      int          narrow;
      int          pick;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty queue, extremes, equal priorities, head and middle removal
      send_request(CMD_DEQUEUE, 32'sd0, 16'd0);
      send_request(CMD_PEEK, 32'sd0, 16'd0);
      send_request(CMD_UNUSED, -32'sd1, 16'hFFFF);
      send_request(CMD_ENQUEUE, 32'sh8000_0000, 16'd0);
      send_request(CMD_ENQUEUE, 32'sh7FFF_FFFF, 16'd0);
      send_request(CMD_ENQUEUE, 32'sd0, 16'd0);
      send_request(CMD_PEEK, 32'sd0, 16'd0);
      send_request(CMD_DEQUEUE, 32'sd0, 16'd0);
      send_request(CMD_ENQUEUE, -32'sd1, 16'hFFFF);
      send_request(CMD_ENQUEUE, 32'sd5, 16'hFFFF);
      send_request(CMD_PEEK, 32'sd0, 16'd0);
      send_request(CMD_UNUSED, 32'sd0, 16'd0);
      send_request(CMD_DEQUEUE, 32'sd0, 16'd0);
      send_request(CMD_DEQUEUE, 32'sd0, 16'd0);
      send_request(CMD_DEQUEUE, 32'sd0, 16'd0);
      send_request(CMD_DEQUEUE, 32'sd0, 16'd0);

      // zero capacity behaves as one
      wait_drained();
      write_capacity(5'd0);
      send_request(CMD_ENQUEUE, 32'sd17, 16'd7);
      send_request(CMD_ENQUEUE, 32'sd18, 16'd9);

      // capacity dropped below the held count
      wait_drained();
      write_capacity(5'd2);
      send_request(CMD_ENQUEUE, 32'sd19, 16'd3);
      wait_drained();
      write_capacity(5'd1);
      send_request(CMD_ENQUEUE, 32'sd20, 16'd1);
      send_request(CMD_DEQUEUE, 32'sd0, 16'd0);
      send_request(CMD_ENQUEUE, 32'sd21, 16'd1);
      send_request(CMD_DEQUEUE, 32'sd0, 16'd0);

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin send_idle_pct = 13; rsp_stall_pct = 48; end
            1: begin send_idle_pct = 48; rsp_stall_pct = 13; end
            default: begin send_idle_pct = 0; rsp_stall_pct = 0; end
         endcase
         for (int chunk = 0; chunk < 8; chunk++) begin
            wait_drained();
            case ($urandom_range(5))
               0: write_capacity(5'd1);
               1: write_capacity(5'd16);
               2: write_capacity(5'd0);
               3: write_capacity(5'd31);
               default: write_capacity(5'($urandom_range(15, 2)));
            endcase
            case ($urandom_range(2))
               0: enq_pct = 30;
               1: enq_pct = 50;
               default: enq_pct = 70;
            endcase
            narrow = $urandom_range(1);
            repeat (60) begin
               pick = $urandom_range(99);
               if (pick < 4)
                  cmd = CMD_UNUSED;
               else if (pick < 4 + enq_pct)
                  cmd = CMD_ENQUEUE;
               else if ($urandom_range(2) == 0)
                  cmd = CMD_PEEK;
               else
                  cmd = CMD_DEQUEUE;
               send_request(cmd, $urandom,
                            narrow ? PRIO_W'($urandom_range(3)) : PRIO_W'($urandom_range(65535)));
            end
         end
      end

      wait_drained();
      repeat (80) @(negedge clock);
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   initial begin
      #2000000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

/* bounded_priority_queue.f */
rtl/bpq_pkg.sv
rtl/bpq_ctrl.sv
rtl/bpq_datapath.sv
rtl/bounded_priority_queue.sv
test/bpq_checker.sv
test/tb_bounded_priority_queue.sv
